FILE: src/brs_pkg.sv
// brs_pkg: shared types, operation codes and size-class helpers of the
// banked register set. No dependencies.
package brs_pkg;

  localparam int unsigned SLOTS  = 16;
  localparam int unsigned SLOT_W = 4;
  localparam int unsigned CLS_W  = 2;
  localparam int unsigned CODE_W = 12;
  localparam int unsigned TAG_W  = 4;
  localparam int unsigned CNT_W  = 7;

  typedef logic [CODE_W-1:0]      code_t;
  typedef logic [TAG_W-1:0]       tag_t;
  typedef logic [SLOT_W-1:0]      slot_t;
  typedef logic [CLS_W-1:0]       cls_t;
  typedef logic [SLOTS*CLS_W-1:0] bank_t;
  typedef logic [CNT_W-1:0]       cnt_t;

  localparam cnt_t CNT_MAX = '1;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_CLEAR  = 2'd3
  } brs_op_e;

  typedef enum logic [1:0] {
    CFG_SP_CODE = 2'd0,
    CFG_FP_CODE = 2'd1
  } brs_cfg_e;

  // size field rebuilt from a stored class
  localparam tag_t SIZE_OF_CLASS [4] = '{4'h0, 4'h4, 4'h0, 4'h8};

  function automatic cls_t class_of_size(tag_t sz);
    cls_t c;
    case (sz)
      4'h1, 4'h4: c = 2'd1;
      4'h8:       c = 2'd3;
      default:    c = 2'd2;
    endcase
    return c;
  endfunction

endpackage

FILE: src/banked_register_set.sv
// banked_register_set: top level of the banked register set.
// Depends on brs_pkg and brs_bank_match.
//
// Usage:
//   input channel  (in_valid_i / in_stall_o): one beat carries operation_i and
//     reg_code_i; insert, remove, lookup or clear all.
//   output channel (out_valid_o / out_stall_i): one beat per input beat with
//     present_o, stored_reg_o, member_count_o and no_room_o describing the
//     slot of reg_code_i and the set after the operation.
//   config channel (cfg_valid_i / cfg_ready_o): index 0 sets the stack pointer
//     code, index 1 the frame pointer code; inserts of either are ignored.
//     Always ready; write only while no beat is in flight.
// A beat passes an input register, then a single pass of bank tag match and
// slot update into the result register. One beat per cycle is sustained
// while the receiver does not stall; the owner tag match and the slot
// read-modify-write are combinational between the input and result registers.
// Reset empties all banks, frees all owner tags, zeroes the count and both
// pointer codes. While the receiver stalls the result holds and one more beat
// waits in the input register, after which in_stall_o rises.
module banked_register_set #(
  parameter int unsigned BANKS = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [1:0]      operation_i,
  input  brs_pkg::code_t  reg_code_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic            present_o,
  output brs_pkg::code_t  stored_reg_o,
  output brs_pkg::cnt_t   member_count_o,
  output logic            no_room_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [1:0]      cfg_index_i,
  input  brs_pkg::code_t  cfg_data_i
);
  import brs_pkg::*;

  logic    s1_valid_q, s1_valid_d;
  logic [1:0] s1_op_q;
  code_t   s1_code_q;
  logic    out_valid_q, out_valid_d;
  logic    adv, s1_fire, in_fire;

  code_t   sp_q, fp_q;
  bank_t   sizes_q [BANKS];
  bank_t   sizes_d [BANKS];
  tag_t [BANKS-1:1] owner_q, owner_d;
  cnt_t    cnt_q, cnt_d;

  brs_op_e op;
  tag_t    backend;
  slot_t   slot;
  cls_t    new_cls, old_cls, merged, post_cls;
  logic    be_zero, pre_hit, free_hit, post_hit;
  logic [BANKS-1:1] pre_sel, free_sel, post_sel;
  logic [BANKS-1:0] found_sel, tgt_sel, post_sel_full;
  logic    found, ins_ok, claim, tgt_valid, no_room_d, present_d;
  code_t   stored_d;

  logic    present_q, no_room_q;
  code_t   stored_q;

  // handshake
  assign adv        = !out_valid_q || !out_stall_i;
  assign s1_fire    = s1_valid_q && adv;
  assign in_stall_o = s1_valid_q && !adv;
  assign in_fire    = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (s1_fire) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_fire) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // decode
  assign op      = brs_op_e'(s1_op_q);
  assign backend = s1_code_q[7:4];
  assign slot    = s1_code_q[3:0];
  assign new_cls = class_of_size(s1_code_q[11:8]);
  assign be_zero = (backend == '0);

  brs_bank_match #(.BANKS(BANKS)) u_pre_match (
    .owner_i (owner_q),
    .key_i   (backend),
    .hit_o   (pre_hit),
    .sel_o   (pre_sel)
  );

  brs_bank_match #(.BANKS(BANKS)) u_free_match (
    .owner_i (owner_q),
    .key_i   ('0),
    .hit_o   (free_hit),
    .sel_o   (free_sel)
  );

  assign found_sel = be_zero ? {{(BANKS-1){1'b0}}, 1'b1} : {pre_sel, 1'b0};
  assign found     = be_zero || pre_hit;
  assign ins_ok    = (op == OP_INSERT) && (s1_code_q != '0) &&
                     (s1_code_q != sp_q) && (s1_code_q != fp_q);
  assign claim     = ins_ok && !found && free_hit;
  assign no_room_d = ins_ok && !found && !free_hit;
  assign tgt_sel   = claim ? {free_sel, 1'b0} : found_sel;
  assign tgt_valid = found || claim;

  always_comb begin
    old_cls = '0;
    for (int unsigned b = 0; b < BANKS; b++) begin
      if (tgt_sel[b]) begin
        old_cls = old_cls | sizes_q[b][{slot, 1'b0} +: CLS_W];
      end
    end
  end

  assign merged = (old_cls > new_cls) ? old_cls : new_cls;

  // slot update per bank
  always_comb begin
    for (int unsigned b = 0; b < BANKS; b++) begin
      sizes_d[b] = sizes_q[b];
      case (op)
        OP_INSERT: begin
          if (ins_ok && tgt_sel[b]) begin
            sizes_d[b][{slot, 1'b0} +: CLS_W] = merged;
          end
        end
        OP_REMOVE: begin
          if (found_sel[b]) begin
            sizes_d[b][{slot, 1'b0} +: CLS_W] = '0;
          end
        end
        OP_CLEAR: begin
          sizes_d[b] = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // owner tags: claim on insert, release when a bank empties
  always_comb begin
    for (int unsigned b = 1; b < BANKS; b++) begin
      owner_d[b] = owner_q[b];
      if (claim && free_sel[b]) begin
        owner_d[b] = backend;
      end
      if (op == OP_REMOVE && found_sel[b] && sizes_d[b] == '0) begin
        owner_d[b] = '0;
      end
      if (op == OP_CLEAR) begin
        owner_d[b] = '0;
      end
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    case (op)
      OP_INSERT: begin
        if (ins_ok && tgt_valid && old_cls == '0 && cnt_q != CNT_MAX) begin
          cnt_d = cnt_q + cnt_t'(1);
        end
      end
      OP_REMOVE: begin
        if (found && old_cls != '0 && cnt_q != '0) begin
          cnt_d = cnt_q - cnt_t'(1);
        end
      end
      OP_CLEAR: begin
        cnt_d = '0;
      end
      default: begin
      end
    endcase
  end

  // lookup on the updated state
  brs_bank_match #(.BANKS(BANKS)) u_post_match (
    .owner_i (owner_d),
    .key_i   (backend),
    .hit_o   (post_hit),
    .sel_o   (post_sel)
  );

  assign post_sel_full = be_zero ? {{(BANKS-1){1'b0}}, 1'b1}
                       : (post_hit ? {post_sel, 1'b0} : '0);

  always_comb begin
    post_cls = '0;
    for (int unsigned b = 0; b < BANKS; b++) begin
      if (post_sel_full[b]) begin
        post_cls = post_cls | sizes_d[b][{slot, 1'b0} +: CLS_W];
      end
    end
  end

  assign present_d = (post_cls != '0);
  assign stored_d  = present_d ? {SIZE_OF_CLASS[post_cls], backend, slot} : '0;

  // control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      owner_q     <= '0;
      cnt_q       <= '0;
      for (int unsigned b = 0; b < BANKS; b++) begin
        sizes_q[b] <= '0;
      end
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (s1_fire) begin
        owner_q <= owner_d;
        cnt_q   <= cnt_d;
        for (int unsigned b = 0; b < BANKS; b++) begin
          sizes_q[b] <= sizes_d[b];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q <= '0;
      fp_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_SP_CODE: sp_q <= cfg_data_i;
        CFG_FP_CODE: fp_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_op_q   <= operation_i;
      s1_code_q <= reg_code_i;
    end
    if (s1_fire) begin
      present_q <= present_d;
      stored_q  <= stored_d;
      no_room_q <= no_room_d;
    end
  end

  assign cfg_ready_o    = 1'b1;
  assign out_valid_o    = out_valid_q;
  assign present_o      = present_q;
  assign stored_reg_o   = stored_q;
  assign member_count_o = cnt_q;
  assign no_room_o      = no_room_q;

  // checks
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> !s1_fire)
    else $error("result overwritten while stalled");

  a_stall_holds_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q)
    else $error("input stalled with empty input register");

  a_absent_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !present_o) |-> (stored_reg_o == '0))
    else $error("absent slot with nonzero stored code");

  a_no_room_absent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && no_room_o) |-> !present_o)
    else $error("no_room with a present slot");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (int'(member_count_o) <= int'(BANKS * SLOTS)))
    else $error("member count above capacity");

endmodule

FILE: src/brs_bank_match.sv
// brs_bank_match: priority tag match over the owner tags of banks 1 and up.
// Depends on brs_pkg.
module brs_bank_match #(
  parameter int unsigned BANKS = 4
) (
  input  brs_pkg::tag_t [BANKS-1:1] owner_i,
  input  brs_pkg::tag_t             key_i,
  output logic                      hit_o,
  output logic [BANKS-1:1]          sel_o
);
  import brs_pkg::*;

  always_comb begin
    hit_o = 1'b0;
    sel_o = '0;
    for (int unsigned b = 1; b < BANKS; b++) begin
      if (!hit_o && owner_i[b] == key_i) begin
        sel_o[b] = 1'b1;
        hit_o    = 1'b1;
      end
    end
  end

endmodule
